### rtl/core/swpt_pkg.sv
// Shared types and constants of the switch-driven parameter tuner.
// Used by swpt_ctrl, swpt_datapath and switch_driven_parameter_tuner.
`timescale 1ns / 1ps

package swpt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_BITS    = 4;
    localparam int CNT_BITS    = 5;
    // step arithmetic width: value plus carry and sign
    localparam int EXT_BITS    = VALUE_BITS + 2;

    // select switch codes
    localparam logic [1:0] SEL_NEUTRAL = 2'd0;
    localparam logic [1:0] SEL_NEXT    = 2'd1;
    localparam logic [1:0] SEL_PREV    = 2'd2;

    // adjust switch codes
    localparam logic [1:0] ADJ_NEUTRAL = 2'd0;
    localparam logic [1:0] ADJ_INC     = 2'd1;
    localparam logic [1:0] ADJ_DEC     = 2'd2;

    // opcode of an input word
    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // config register byte addresses
    localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] min;
        logic [VALUE_BITS-1:0] max;
        logic [VALUE_BITS-1:0] step;
    } t_entry;

    // controller to datapath commands, one step of the sequence each
    typedef struct packed {
        logic capture;   // latch the accepted input word
        logic select;    // load write or selection update
        logic read;      // read the selected entry
        logic step;      // apply step, write back, load result
    } t_dp_cmd;

endpackage

### rtl/core/switch_driven_parameter_tuner.sv
// Switch-driven parameter tuner.
// Input channel (i_in_valid/o_in_ready) carries load words, which write one
// table entry, and control words, which walk the entry list with the
// next/prev switches and step the selected value with the inc/dec switches.
// Output channel (o_out_valid/i_out_ready) returns one result word per input
// word: active flag, selected index and value, display and change flags.
// APB port: register entry_count at byte address 0; pready is tied high.
// Each accepted word goes through the capture, select, read and step states,
// and the result is registered; a new word is accepted only once the previous
// one has left the step state, as the sequencer takes one word at a time.
// The output register holds a result while the receiver stalls; the next
// word is accepted meanwhile and waits in its step cycle until the result
// register is free.
// Reset (synchronous, active low) clears the selection state, switch history,
// entry_count, the sequencer state and the output valid flag. The entry table
// is not cleared; entries must be loaded before they are selected.
// Depends on swpt_pkg, swpt_ctrl and swpt_datapath.
`timescale 1ns / 1ps

module switch_driven_parameter_tuner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic                              i_link_up,
    input  logic                              i_new_packet,
    input  logic                              i_next_request,
    input  logic                              i_prev_request,
    input  logic                              i_inc_request,
    input  logic                              i_dec_request,
    input  logic [swpt_pkg::IDX_BITS-1:0]     i_entry_index,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_value,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_min,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_max,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_step,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_tuning_active,
    output logic [swpt_pkg::IDX_BITS-1:0]     o_selected_index,
    output logic [swpt_pkg::VALUE_BITS-1:0]   o_selected_value,
    output logic                              o_display_update,
    output logic                              o_value_changed
);
    import swpt_pkg::*;

    logic [CNT_BITS-1:0] r_entry_count;
    logic                w_wr;
    t_dp_cmd             w_cmd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (w_wr && {paddr[2], 2'b00} == ADDR_ENTRY_COUNT) begin
            r_entry_count <= pwdata[CNT_BITS-1:0];
        end
    end

    assign prdata = ({paddr[2], 2'b00} == ADDR_ENTRY_COUNT)
                    ? {{(32-CNT_BITS){1'b0}}, r_entry_count} : 32'd0;

    swpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    swpt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_entry_count    (r_entry_count),
        .i_opcode         (i_opcode),
        .i_link_up        (i_link_up),
        .i_new_packet     (i_new_packet),
        .i_next_request   (i_next_request),
        .i_prev_request   (i_prev_request),
        .i_inc_request    (i_inc_request),
        .i_dec_request    (i_dec_request),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_entry_min      (i_entry_min),
        .i_entry_max      (i_entry_max),
        .i_entry_step     (i_entry_step),
        .o_tuning_active  (o_tuning_active),
        .o_selected_index (o_selected_index),
        .o_selected_value (o_selected_value),
        .o_display_update (o_display_update),
        .o_value_changed  (o_value_changed)
    );

endmodule

### rtl/core/swpt_ctrl.sv
// Sequencer of the tuner: steps each word through capture, select, read and step.
// Depends on swpt_pkg; drives the datapath commands and the handshake flags.
`timescale 1ns / 1ps

module swpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output swpt_pkg::t_dp_cmd o_cmd
);
    import swpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_READ,
        S_STEP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_step_go;

    // the result register may be refilled in the cycle it is taken
    assign w_step_go = (r_state == S_STEP) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SEL;
                end
            end
            S_SEL:  n_state = S_READ;
            S_READ: n_state = S_STEP;
            S_STEP: begin
                if (w_step_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.select  = (r_state == S_SEL);
    assign o_cmd.read    = (r_state == S_READ);
    assign o_cmd.step    = w_step_go;

endmodule

### rtl/core/swpt_datapath.sv
// Datapath of the tuner: entry table, selection state, step arithmetic, result word.
// Depends on swpt_pkg; sequenced by swpt_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module swpt_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swpt_pkg::t_dp_cmd                 i_cmd,
    input  logic [swpt_pkg::CNT_BITS-1:0]     i_entry_count,
    input  logic                              i_opcode,
    input  logic                              i_link_up,
    input  logic                              i_new_packet,
    input  logic                              i_next_request,
    input  logic                              i_prev_request,
    input  logic                              i_inc_request,
    input  logic                              i_dec_request,
    input  logic [swpt_pkg::IDX_BITS-1:0]     i_entry_index,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_value,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_min,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_max,
    input  logic [swpt_pkg::VALUE_BITS-1:0]   i_entry_step,
    output logic                              o_tuning_active,
    output logic [swpt_pkg::IDX_BITS-1:0]     o_selected_index,
    output logic [swpt_pkg::VALUE_BITS-1:0]   o_selected_value,
    output logic                              o_display_update,
    output logic                              o_value_changed
);
    import swpt_pkg::*;

    // entry table, one write and one registered read per cycle
    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;

    // captured input word
    logic                  r_op, r_gate;
    logic [1:0]            r_sel, r_adj;
    logic [IDX_BITS-1:0]   r_idx;
    t_entry                r_load;

    // selection state
    logic                  r_active, n_active;
    logic [IDX_BITS-1:0]   r_cur, n_cur;
    logic [1:0]            r_last_sel, n_last_sel;
    logic [1:0]            r_last_adj, n_last_adj;
    logic                  r_disp, n_disp;
    logic                  r_pend, n_pend;
    logic                  r_up;

    // result word
    logic                  r_o_active;
    logic [IDX_BITS-1:0]   r_o_index;
    logic [VALUE_BITS-1:0] r_o_value;
    logic                  r_o_disp, r_o_changed;

    logic [CNT_BITS-1:0]   w_n;
    logic [CNT_BITS-1:0]   w_cur_ext;
    logic signed [EXT_BITS-1:0] w_v, w_s, w_lo, w_hi, w_res;
    logic [VALUE_BITS-1:0] w_new_val;
    t_entry                w_wb;

    assign w_n = (i_entry_count > CNT_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES)
                                                          : i_entry_count;
    assign w_cur_ext = {1'b0, r_cur};

    always_comb begin
        n_active   = r_active;
        n_cur      = r_cur;
        n_last_sel = r_last_sel;
        n_last_adj = r_last_adj;
        n_disp     = 1'b0;
        n_pend     = 1'b0;
        if (r_op == OP_CONTROL && r_gate) begin
            // stale selection after the count shrank
            if (n_active && w_cur_ext >= w_n) begin
                n_active = 1'b0;
                n_disp   = 1'b1;
            end
            if (r_sel != r_last_sel) begin
                if (n_active) begin
                    if (r_sel == SEL_NEXT) begin
                        if (w_cur_ext + 1'b1 >= w_n) begin
                            n_active = 1'b0;
                        end else begin
                            n_cur = r_cur + 1'b1;
                        end
                        n_disp = 1'b1;
                    end else if (r_sel == SEL_PREV) begin
                        if (r_cur == '0) begin
                            n_active = 1'b0;
                        end else begin
                            n_cur = r_cur - 1'b1;
                        end
                        n_disp = 1'b1;
                    end
                end else if (w_n != '0 && r_sel != SEL_NEUTRAL) begin
                    n_active = 1'b1;
                    n_cur    = (r_sel == SEL_NEXT) ? '0 : IDX_BITS'(w_n - 1'b1);
                    n_disp   = 1'b1;
                end
                n_last_sel = r_sel;
            end
            if (r_adj != r_last_adj) begin
                n_pend     = (r_adj != ADJ_NEUTRAL) && n_active;
                n_last_adj = r_adj;
            end
        end
    end

    // exact signed arithmetic, two bits wider than the value
    assign w_v   = $signed({2'b00, r_rd.value});
    assign w_s   = $signed({2'b00, r_rd.step});
    assign w_lo  = $signed({2'b00, r_rd.min});
    assign w_hi  = $signed({2'b00, r_rd.max});
    assign w_res = r_up ? (w_v + w_s) : (w_v - w_s);
    assign w_new_val = (w_res > w_hi || w_res < w_lo) ? r_rd.max
                                                      : w_res[VALUE_BITS-1:0];

    always_comb begin
        w_wb       = r_rd;
        w_wb.value = w_new_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_cur      <= '0;
            r_last_sel <= SEL_NEUTRAL;
            r_last_adj <= ADJ_NEUTRAL;
        end else if (i_cmd.select) begin
            r_active   <= n_active;
            r_cur      <= n_cur;
            r_last_sel <= n_last_sel;
            r_last_adj <= n_last_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_opcode;
            r_gate      <= i_link_up & i_new_packet;
            r_sel       <= i_prev_request ? SEL_PREV :
                           (i_next_request ? SEL_NEXT : SEL_NEUTRAL);
            r_adj       <= i_dec_request ? ADJ_DEC :
                           (i_inc_request ? ADJ_INC : ADJ_NEUTRAL);
            r_idx       <= i_entry_index;
            r_load      <= '{value: i_entry_value, min: i_entry_min,
                             max: i_entry_max, step: i_entry_step};
        end
        if (i_cmd.select) begin
            r_disp <= n_disp;
            r_pend <= n_pend;
            r_up   <= (r_adj == ADJ_INC);
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[r_cur];
        end
        if (i_cmd.step) begin
            r_o_active  <= r_active;
            r_o_index   <= r_active ? r_cur : '0;
            r_o_value   <= !r_active ? '0 : (r_pend ? w_new_val : r_rd.value);
            r_o_disp    <= r_disp | r_pend;
            r_o_changed <= r_pend;
        end
    end

    // memory writes: loads in the select step, write-back in the step cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.select && r_op == OP_LOAD) begin
            r_mem[r_idx] <= r_load;
        end else if (i_cmd.step && r_pend) begin
            r_mem[r_cur] <= w_wb;
        end
    end

    assign o_tuning_active  = r_o_active;
    assign o_selected_index = r_o_index;
    assign o_selected_value = r_o_value;
    assign o_display_update = r_o_disp;
    assign o_value_changed  = r_o_changed;

endmodule

### bench/swpt_result_checker.sv
// Result checker for the switch-driven parameter tuner: tracks entry_count from
// APB writes, predicts one result per accepted input word and compares results.
// Depends on swpt_pkg.
`timescale 1ns / 1ps

module swpt_result_checker
    import swpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_opcode,
    input  logic                  i_link_up,
    input  logic                  i_new_packet,
    input  logic                  i_next_request,
    input  logic                  i_prev_request,
    input  logic                  i_inc_request,
    input  logic                  i_dec_request,
    input  logic [IDX_BITS-1:0]   i_entry_index,
    input  logic [VALUE_BITS-1:0] i_entry_value,
    input  logic [VALUE_BITS-1:0] i_entry_min,
    input  logic [VALUE_BITS-1:0] i_entry_max,
    input  logic [VALUE_BITS-1:0] i_entry_step,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_tuning_active,
    input  logic [IDX_BITS-1:0]   i_selected_index,
    input  logic [VALUE_BITS-1:0] i_selected_value,
    input  logic                  i_display_update,
    input  logic                  i_value_changed,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_stepped
);

    typedef struct packed {
        logic                  active;
        logic [IDX_BITS-1:0]   index;
        logic [VALUE_BITS-1:0] value;
        logic                  disp;
        logic                  changed;
    } tuner_result_t;

    tuner_result_t awaited_results[$];

    logic                  sel_on;
    logic [IDX_BITS-1:0]   cur_entry;
    logic [1:0]            prev_sel;
    logic [1:0]            prev_adj;
    logic [CNT_BITS-1:0]   count_reg;
    logic [VALUE_BITS-1:0] tbl_value [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] tbl_min   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] tbl_max   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] tbl_step  [MAX_ENTRIES];

    int n_fail    = 0;
    int n_checked = 0;
    int n_stepped = 0;

    assign o_fail_count = n_fail;
    assign o_pending    = awaited_results.size();
    assign o_checked    = n_checked;
    assign o_stepped    = n_stepped;

    // Applies one input word to the tuner state and returns the status it reports.
    function automatic tuner_result_t next_tuner_result(
        input logic                  op,
        input logic                  link,
        input logic                  pkt,
        input logic                  nxt,
        input logic                  prv,
        input logic                  inc,
        input logic                  dec,
        input logic [IDX_BITS-1:0]   idx,
        input logic [VALUE_BITS-1:0] val,
        input logic [VALUE_BITS-1:0] mn,
        input logic [VALUE_BITS-1:0] mx,
        input logic [VALUE_BITS-1:0] stp
    );
        tuner_result_t r;
        int            n;
        int            sum;
        logic [1:0]    sel;
        logic [1:0]    adj;
        r = '0;
        if (op == OP_LOAD) begin
            tbl_value[idx] = val;
            tbl_min[idx]   = mn;
            tbl_max[idx]   = mx;
            tbl_step[idx]  = stp;
        end else if (link && pkt) begin
            n   = (int'(count_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
            sel = prv ? SEL_PREV : (nxt ? SEL_NEXT : SEL_NEUTRAL);
            adj = dec ? ADJ_DEC : (inc ? ADJ_INC : ADJ_NEUTRAL);
            // count shrank under the selection
            if (sel_on && int'(cur_entry) >= n) begin
                sel_on = 1'b0;
                r.disp = 1'b1;
            end
            if (sel != prev_sel) begin
                if (sel_on) begin
                    if (sel == SEL_NEXT) begin
                        if (int'(cur_entry) + 1 >= n) sel_on = 1'b0;
                        else cur_entry = cur_entry + 1'b1;
                        r.disp = 1'b1;
                    end else if (sel == SEL_PREV) begin
                        if (cur_entry == '0) sel_on = 1'b0;
                        else cur_entry = cur_entry - 1'b1;
                        r.disp = 1'b1;
                    end
                end else if (n > 0 && sel != SEL_NEUTRAL) begin
                    sel_on    = 1'b1;
                    cur_entry = (sel == SEL_NEXT) ? '0 : IDX_BITS'(n - 1);
                    r.disp    = 1'b1;
                end
                prev_sel = sel;
            end
            if (adj != prev_adj) begin
                if (adj != ADJ_NEUTRAL && sel_on) begin
                    // exact sum, out of range snaps to the maximum either way
                    if (adj == ADJ_INC)
                        sum = int'(tbl_value[cur_entry]) + int'(tbl_step[cur_entry]);
                    else
                        sum = int'(tbl_value[cur_entry]) - int'(tbl_step[cur_entry]);
                    if (sum > int'(tbl_max[cur_entry]) || sum < int'(tbl_min[cur_entry]))
                        sum = int'(tbl_max[cur_entry]);
                    tbl_value[cur_entry] = sum[VALUE_BITS-1:0];
                    r.changed = 1'b1;
                    r.disp    = 1'b1;
                end
                prev_adj = adj;
            end
        end
        r.active = sel_on;
        if (sel_on) begin
            r.index = cur_entry;
            r.value = tbl_value[cur_entry];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        tuner_result_t seen;
        tuner_result_t want;
        if (!i_rst_n) begin
            sel_on    = 1'b0;
            cur_entry = '0;
            prev_sel  = SEL_NEUTRAL;
            prev_adj  = ADJ_NEUTRAL;
            count_reg = '0;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ENTRY_COUNT)
                count_reg = pwdata[CNT_BITS-1:0];
            if (i_out_valid && i_out_ready) begin
                seen = '{i_tuning_active, i_selected_index, i_selected_value,
                         i_display_update, i_value_changed};
                if (awaited_results.size() == 0) begin
                    if (n_fail < 10) begin
                        $display("[%0t] result word with nothing awaited:", $realtime);
                        $display("    active=%0d idx=%0d val=%h disp=%0d chg=%0d",
                                 seen.active, seen.index, seen.value,
                                 seen.disp, seen.changed);
                    end
                    n_fail++;
                end else begin
                    want = awaited_results.pop_front();
                    n_checked++;
                    if (seen !== want) begin
                        if (n_fail < 10) begin
                            $display("[%0t] mismatch:", $realtime);
                            $display("    exp active=%0d idx=%0d val=%h disp=%0d chg=%0d",
                                     want.active, want.index, want.value,
                                     want.disp, want.changed);
                            $display("    got active=%0d idx=%0d val=%h disp=%0d chg=%0d",
                                     seen.active, seen.index, seen.value,
                                     seen.disp, seen.changed);
                        end
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = next_tuner_result(i_opcode, i_link_up, i_new_packet,
                                         i_next_request, i_prev_request,
                                         i_inc_request, i_dec_request, i_entry_index,
                                         i_entry_value, i_entry_min, i_entry_max,
                                         i_entry_step);
                if (want.changed) n_stepped++;
                awaited_results.push_back(want);
            end
        end
    end

endmodule

### bench/tb_switch_driven_parameter_tuner.sv
// Top of the switch-driven parameter tuner bench: clock, reset, APB writes of
// entry_count, directed and random words with random gaps, and the verdict.
// Depends on swpt_pkg, swpt_result_checker and switch_driven_parameter_tuner.
`timescale 1ns / 1ps

module tb_switch_driven_parameter_tuner;
    import swpt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int BLOCK_LATENCY = 4;
    localparam int PHASE_WORDS   = 84;

    typedef struct {
        logic                  op;
        logic                  link;
        logic                  pkt;
        logic                  nxt;
        logic                  prv;
        logic                  inc;
        logic                  dec;
        logic [IDX_BITS-1:0]   idx;
        logic [VALUE_BITS-1:0] val;
        logic [VALUE_BITS-1:0] mn;
        logic [VALUE_BITS-1:0] mx;
        logic [VALUE_BITS-1:0] stp;
    } tuner_word_t;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [2:0]            paddr            = '0;
    logic [31:0]           pwdata           = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic                  i_opcode         = OP_CONTROL;
    logic                  i_link_up        = 1'b0;
    logic                  i_new_packet     = 1'b0;
    logic                  i_next_request   = 1'b0;
    logic                  i_prev_request   = 1'b0;
    logic                  i_inc_request    = 1'b0;
    logic                  i_dec_request    = 1'b0;
    logic [IDX_BITS-1:0]   i_entry_index    = '0;
    logic [VALUE_BITS-1:0] i_entry_value    = '0;
    logic [VALUE_BITS-1:0] i_entry_min      = '0;
    logic [VALUE_BITS-1:0] i_entry_max      = '0;
    logic [VALUE_BITS-1:0] i_entry_step     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic                  o_tuning_active;
    logic [IDX_BITS-1:0]   o_selected_index;
    logic [VALUE_BITS-1:0] o_selected_value;
    logic                  o_display_update;
    logic                  o_value_changed;

    int fail_count;
    int pending;
    int checked;
    int stepped;

    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;
    int n_loads     = 0;
    int n_controls  = 0;
    int n_settings  = 0;
    int rx_taken    = 0;
    int rx_seen     = 0;
    int rx_gap      = 3;
    int cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    switch_driven_parameter_tuner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_link_up        (i_link_up),
        .i_new_packet     (i_new_packet),
        .i_next_request   (i_next_request),
        .i_prev_request   (i_prev_request),
        .i_inc_request    (i_inc_request),
        .i_dec_request    (i_dec_request),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_entry_min      (i_entry_min),
        .i_entry_max      (i_entry_max),
        .i_entry_step     (i_entry_step),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_tuning_active  (o_tuning_active),
        .o_selected_index (o_selected_index),
        .o_selected_value (o_selected_value),
        .o_display_update (o_display_update),
        .o_value_changed  (o_value_changed)
    );

    swpt_result_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_link_up        (i_link_up),
        .i_new_packet     (i_new_packet),
        .i_next_request   (i_next_request),
        .i_prev_request   (i_prev_request),
        .i_inc_request    (i_inc_request),
        .i_dec_request    (i_dec_request),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_entry_min      (i_entry_min),
        .i_entry_max      (i_entry_max),
        .i_entry_step     (i_entry_step),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_tuning_active  (o_tuning_active),
        .i_selected_index (o_selected_index),
        .i_selected_value (o_selected_value),
        .i_display_update (o_display_update),
        .i_value_changed  (o_value_changed),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_stepped        (stepped)
    );

    // receiver: after each taken result word, stall a random number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) rx_taken <= rx_taken + 1;
    end

    always @(negedge i_clk) begin
        if (rx_taken != rx_seen) begin
            rx_seen = rx_taken;
            rx_gap  = rx_burst ? 0 : $urandom_range(0, 10);
        end
        if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic tuner_word_t ctrl_word(input logic link, input logic pkt,
                                              input logic nxt, input logic prv,
                                              input logic inc, input logic dec);
        tuner_word_t w;
        w.op   = OP_CONTROL;
        w.link = link;
        w.pkt  = pkt;
        w.nxt  = nxt;
        w.prv  = prv;
        w.inc  = inc;
        w.dec  = dec;
        // payload fields are don't-care on control words
        w.idx  = $urandom_range(0, MAX_ENTRIES - 1);
        w.val  = $urandom;
        w.mn   = $urandom;
        w.mx   = $urandom;
        w.stp  = $urandom;
        return w;
    endfunction

    function automatic tuner_word_t load_word(input int idx, input int val, input int mn,
                                              input int mx, input int stp);
        tuner_word_t w;
        w      = ctrl_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        w.op   = OP_LOAD;
        w.idx  = idx[IDX_BITS-1:0];
        w.val  = val[VALUE_BITS-1:0];
        w.mn   = mn[VALUE_BITS-1:0];
        w.mx   = mx[VALUE_BITS-1:0];
        w.stp  = stp[VALUE_BITS-1:0];
        return w;
    endfunction

    // Random entry with min <= value <= max and a step that walks the range.
    function automatic tuner_word_t sane_load(input int idx);
        int mn;
        int mx;
        mn = $urandom_range(0, 16'hFFFF);
        mx = $urandom_range(mn, 16'hFFFF);
        return load_word(idx, $urandom_range(mn, mx), mn, mx,
                         $urandom_range(0, (mx - mn) / 4 + 1));
    endfunction

    function automatic tuner_word_t random_word();
        tuner_word_t w;
        int          pick;
        int          s;
        int          a;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            w = sane_load($urandom_range(0, MAX_ENTRIES - 1));
        end else if (pick < 10) begin
            w = load_word($urandom_range(0, MAX_ENTRIES - 1), $urandom, $urandom,
                          $urandom, $urandom);
        end else begin
            // select: neutral, next, prev or both; adjust likewise
            s = $urandom_range(0, 9);
            a = $urandom_range(0, 9);
            w = ctrl_word(1'b1, 1'b1, s inside {[4:6], 9}, s inside {[7:9]},
                          a inside {[4:6], 9}, a inside {[7:9]});
            if (pick < 18) begin
                w.link = $urandom;
                w.pkt  = $urandom;
            end
        end
        return w;
    endfunction

    task automatic send_word(input tuner_word_t w);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= w.op;
        i_link_up      <= w.link;
        i_new_packet   <= w.pkt;
        i_next_request <= w.nxt;
        i_prev_request <= w.prv;
        i_inc_request  <= w.inc;
        i_dec_request  <= w.dec;
        i_entry_index  <= w.idx;
        i_entry_value  <= w.val;
        i_entry_min    <= w.mn;
        i_entry_max    <= w.mx;
        i_entry_step   <= w.stp;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (w.op == OP_LOAD) n_loads++;
        else n_controls++;
    endtask

    // block goes idle: every awaited result taken, plus the pipeline depth
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (BLOCK_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_entry_count(input int count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRY_COUNT;
        pwdata  <= count;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        int phase_counts[9];
        int pc;
        phase_counts = '{16, 1, 0, 16, -1, 2, 16, -1, 15};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // count is 0 out of reset: gated words, then the empty list
        send_word(ctrl_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(ctrl_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(ctrl_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_word(ctrl_word(1'b1, 1'b1, 1'b0, 1'b0, 0, 0));
        send_word(load_word(0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_word(load_word(MAX_ENTRIES - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        drain_results();
        write_entry_count(MAX_ENTRIES);

        send_word(ctrl_word(1, 1, 1, 0, 0, 0));   // enter at first entry
        send_word(ctrl_word(1, 1, 1, 0, 0, 1));   // underflow snaps to max
        send_word(ctrl_word(1, 1, 1, 0, 1, 0));   // overflow snaps to max
        send_word(ctrl_word(1, 1, 0, 0, 0, 0));
        send_word(ctrl_word(1, 1, 0, 1, 0, 0));   // prev on first entry leaves
        send_word(ctrl_word(1, 1, 0, 0, 0, 0));
        send_word(ctrl_word(1, 1, 0, 1, 0, 0));   // enter at last entry
        send_word(ctrl_word(1, 1, 0, 1, 1, 0));   // zero step still counts
        send_word(load_word(MAX_ENTRIES - 1, 16'h1234, 16'h0000, 16'hFFFF, 16'h0010));
        send_word(ctrl_word(1, 1, 1, 1, 0, 0));   // prev wins over next
        send_word(ctrl_word(1, 1, 0, 0, 0, 0));
        send_word(ctrl_word(1, 1, 1, 0, 0, 0));   // next on last entry leaves
        send_word(ctrl_word(1, 1, 0, 0, 0, 0));
        send_word(ctrl_word(1, 1, 0, 1, 0, 1));
        drain_results();
        write_entry_count(3);
        send_word(ctrl_word(1, 1, 0, 1, 0, 1));   // selection now past the count
        send_word(ctrl_word(1, 1, 0, 0, 0, 0));
        send_word(ctrl_word(1, 1, 1, 0, 1, 1));   // dec wins over inc

        // fill the whole table before any count can reach unloaded entries
        for (int i = 0; i < MAX_ENTRIES; i++) send_word(sane_load(i));

        for (int p = 0; p < 9; p++) begin
            drain_results();
            pc = (phase_counts[p] < 0) ? $urandom_range(2, MAX_ENTRIES - 1) : phase_counts[p];
            write_entry_count(pc);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_WORDS; k++) send_word(random_word());
        end
        drain_results();

        $display("covered %0d load and %0d control words across %0d entry_count settings",
                 n_loads, n_controls, n_settings);
        $display("checked %0d result words, %0d of them with a value step", checked, stepped);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
